/* hw/rtl/parallel_io_port_interrupt_controller_core_macros.svh */
// Assertion helpers for the parallel I/O controller core.
`ifndef PARALLEL_IO_PORT_INTERRUPT_CONTROLLER_CORE_MACROS_SVH
`define PARALLEL_IO_PORT_INTERRUPT_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTH

`define PIO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PIO_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define PIO_ASSERT(lbl, prop, msg)

`define PIO_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

/* hw/rtl/pio_pkg.sv */
package pio_pkg;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_TAKE   = 3'd2,
    REQ_STROBE = 3'd3,
    REQ_ACK    = 3'd4,
    REQ_RETI   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    MODE_OUTPUT = 2'd0,
    MODE_INPUT  = 2'd1,
    MODE_BIDIR  = 2'd2,
    MODE_BITCTL = 2'd3
  } mode_e;

  localparam logic [7:0] VEC_MASK   = 8'hFE;
  localparam logic [3:0] CW_MODE    = 4'hF;
  localparam logic [3:0] CW_INT_CTL = 4'h7;
  localparam logic [3:0] CW_INT_EN  = 4'h3;
  localparam int unsigned CW_BIT_IE       = 7;
  localparam int unsigned CW_BIT_MASK_NXT = 4;
  localparam logic [7:0] RD_ALL_ONES = 8'hFF;
  localparam logic [7:0] RD_ZERO     = 8'h00;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] reg_addr;
    logic       port_sel;
    logic [7:0] wdata;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       out_valid;
    logic       irq_pending;
    logic       irq_in_service;
  } out_beat_t;

  typedef struct packed {
    logic       data_wr;
    logic       ctrl_wr;
    logic       take;
    logic       strobe;
    logic       ack;
    logic       reti;
    logic [7:0] wdata;
  } port_cmd_t;

  typedef struct packed {
    logic [7:0] int_vector;
    mode_e      mode;
    logic [7:0] output_latch;
    logic       irq_request;
    logic       in_service;
    logic       output_pending;
    logic       irq_request_nxt;
    logic       in_service_nxt;
  } port_sts_t;

endpackage

/* hw/rtl/parallel_io_port_interrupt_controller_core.sv */
// Path: an accepted input beat passes the input register, then the result register, to its result beat;
// the port state updates in the same cycle the result is captured.
// Throughput: one beat per cycle; only a stalled result register with a full input
// register holds off the input side.
// Reset: asynchronous, active low; clears all port state to its power-up values.
`include "parallel_io_port_interrupt_controller_core_macros.svh"

module parallel_io_port_interrupt_controller_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pio_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pio_pkg::out_beat_t  out_beat_o
);

  logic               in_vld_q;
  pio_pkg::in_beat_t  in_q;
  logic               out_vld_q;
  pio_pkg::out_beat_t out_q, out_d;
  logic               adv;
  logic               in_acc;

  pio_pkg::port_cmd_t cmd [2];
  pio_pkg::port_sts_t sts [2];

  logic ap;
  logic ack0, ack1, reti0, reti1;

  assign adv        = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_beat_i;
    if (adv) out_q <= out_d;
  end

  assign ap = in_q.reg_addr[1];

  assign ack0  = !sts[0].in_service && sts[0].irq_request;
  assign ack1  = !sts[0].in_service && !sts[0].irq_request &&
                 !sts[1].in_service && sts[1].irq_request;
  assign reti0 = sts[0].in_service;
  assign reti1 = !sts[0].in_service && sts[1].in_service;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      cmd[p] = '0;
      cmd[p].wdata = in_q.wdata;
    end
    out_d = '0;
    if (adv) begin
      case (pio_pkg::req_e'(in_q.req_type))
        pio_pkg::REQ_READ: begin
          if (in_q.reg_addr[0]) begin
            out_d.rdata = pio_pkg::RD_ALL_ONES;
          end else if (sts[ap].mode == pio_pkg::MODE_OUTPUT) begin
            out_d.rdata = sts[ap].output_latch;
          end else begin
            out_d.rdata = pio_pkg::RD_ALL_ONES;
          end
        end
        pio_pkg::REQ_WRITE: begin
          cmd[ap].ctrl_wr = in_q.reg_addr[0];
          cmd[ap].data_wr = !in_q.reg_addr[0];
        end
        pio_pkg::REQ_TAKE: begin
          if (sts[in_q.port_sel].output_pending) begin
            cmd[in_q.port_sel].take = 1'b1;
            out_d.rdata     = sts[in_q.port_sel].output_latch;
            out_d.out_valid = 1'b1;
          end
        end
        pio_pkg::REQ_STROBE: begin
          cmd[in_q.port_sel].strobe = 1'b1;
        end
        pio_pkg::REQ_ACK: begin
          cmd[0].ack  = ack0;
          cmd[1].ack  = ack1;
          out_d.rdata = ack1 ? sts[1].int_vector : sts[0].int_vector;
        end
        pio_pkg::REQ_RETI: begin
          cmd[0].reti = reti0;
          cmd[1].reti = reti1;
        end
        default: begin
        end
      endcase
    end
    out_d.irq_pending = !sts[0].in_service_nxt &&
                        (sts[0].irq_request_nxt ||
                         (!sts[1].in_service_nxt && sts[1].irq_request_nxt));
    out_d.irq_in_service = sts[0].in_service_nxt || sts[1].in_service_nxt;
  end

  pio_port u_port_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd[0]),
    .sts_o  (sts[0])
  );

  pio_port u_port_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd[1]),
    .sts_o  (sts[1])
  );

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  `PIO_ASSERT(a_adv_fills_out, adv |=> out_vld_q, "advanced beat did not reach result register")
  `PIO_ASSERT(a_ack_in_service, (adv && in_q.req_type == pio_pkg::REQ_ACK && (ack0 || ack1)) |=> out_q.irq_in_service, "granted acknowledge not reported in service")
  `PIO_ASSERT(a_pending_matches, adv |=> (out_q.irq_pending == (!sts[0].in_service && (sts[0].irq_request || (!sts[1].in_service && sts[1].irq_request)))), "pending flag disagrees with daisy chain")
  `PIO_ASSERT_NEVER(a_double_grant, ack0 && ack1, "both ports granted")

endmodule

/* hw/rtl/pio_port.sv */
module pio_port (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pio_pkg::port_cmd_t    cmd_i,
  output pio_pkg::port_sts_t    sts_o
);

  logic [7:0]     vec_q, vec_d;
  pio_pkg::mode_e mode_q, mode_d;
  logic [7:0]     latch_q, latch_d;
  logic           ie_q, ie_d;
  logic           ireq_q, ireq_d;
  logic           isvc_q, isvc_d;
  logic           pend_q, pend_d;
  logic           await_dir_q, await_dir_d;
  logic           await_int_q, await_int_d;

  always_comb begin
    vec_d       = vec_q;
    mode_d      = mode_q;
    latch_d     = latch_q;
    ie_d        = ie_q;
    ireq_d      = ireq_q;
    isvc_d      = isvc_q;
    pend_d      = pend_q;
    await_dir_d = await_dir_q;
    await_int_d = await_int_q;

    if (cmd_i.ctrl_wr) begin
      if (await_dir_q) begin
        await_dir_d = 1'b0;
      end else if (await_int_q) begin
        await_int_d = 1'b0;
      end else if (!cmd_i.wdata[0]) begin
        vec_d = cmd_i.wdata & pio_pkg::VEC_MASK;
      end else begin
        case (cmd_i.wdata[3:0])
          pio_pkg::CW_MODE: begin
            mode_d      = pio_pkg::mode_e'(cmd_i.wdata[7:6]);
            await_dir_d = (cmd_i.wdata[7:6] == pio_pkg::MODE_BITCTL);
            pend_d      = 1'b0;
          end
          pio_pkg::CW_INT_CTL: begin
            ie_d        = cmd_i.wdata[pio_pkg::CW_BIT_IE];
            await_int_d = cmd_i.wdata[pio_pkg::CW_BIT_MASK_NXT];
            if (!cmd_i.wdata[pio_pkg::CW_BIT_IE]) ireq_d = 1'b0;
          end
          pio_pkg::CW_INT_EN: begin
            ie_d = cmd_i.wdata[pio_pkg::CW_BIT_IE];
            if (!cmd_i.wdata[pio_pkg::CW_BIT_IE]) ireq_d = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd_i.data_wr) begin
      latch_d = cmd_i.wdata;
      pend_d  = 1'b1;
    end
    if (cmd_i.take) pend_d = 1'b0;
    if (cmd_i.strobe && ie_q) ireq_d = 1'b1;
    if (cmd_i.ack) begin
      ireq_d = 1'b0;
      isvc_d = 1'b1;
    end
    if (cmd_i.reti) isvc_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q       <= '0;
      mode_q      <= pio_pkg::MODE_INPUT;
      latch_q     <= '0;
      ie_q        <= 1'b0;
      ireq_q      <= 1'b0;
      isvc_q      <= 1'b0;
      pend_q      <= 1'b0;
      await_dir_q <= 1'b0;
      await_int_q <= 1'b0;
    end else begin
      vec_q       <= vec_d;
      mode_q      <= mode_d;
      latch_q     <= latch_d;
      ie_q        <= ie_d;
      ireq_q      <= ireq_d;
      isvc_q      <= isvc_d;
      pend_q      <= pend_d;
      await_dir_q <= await_dir_d;
      await_int_q <= await_int_d;
    end
  end

  assign sts_o.int_vector      = vec_q;
  assign sts_o.mode            = mode_q;
  assign sts_o.output_latch    = latch_q;
  assign sts_o.irq_request     = ireq_q;
  assign sts_o.in_service      = isvc_q;
  assign sts_o.output_pending  = pend_q;
  assign sts_o.irq_request_nxt = ireq_d;
  assign sts_o.in_service_nxt  = isvc_d;

endmodule

/* sim/parallel_io_port_interrupt_controller_core_chk.sv */
`timescale 1ns / 100ps

module parallel_io_port_interrupt_controller_core_chk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  pio_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  pio_pkg::out_beat_t out_beat_i,
  output int                 err_cnt_o,
  output int                 pend_cnt_o
);

  logic [7:0]     vec_q      [2];
  pio_pkg::mode_e mode_q     [2];
  logic [7:0]     dir_mask_q [2];
  logic [7:0]     out_latch_q[2];
  logic [7:0]     in_latch_q [2];
  logic           irq_en_q   [2];
  logic           irq_req_q  [2];
  logic           in_svc_q   [2];
  logic           out_pend_q [2];
  logic           wait_dir_q [2];
  logic           wait_imsk_q[2];

  pio_pkg::out_beat_t exp_beats_q[$];
  pio_pkg::out_beat_t want;

  task automatic clear_ports();
    for (int p = 0; p < 2; p++) begin
      vec_q[p]       = '0;
      mode_q[p]      = pio_pkg::MODE_INPUT;
      dir_mask_q[p]  = pio_pkg::RD_ALL_ONES;
      out_latch_q[p] = pio_pkg::RD_ZERO;
      in_latch_q[p]  = pio_pkg::RD_ALL_ONES;
      irq_en_q[p]    = 1'b0;
      irq_req_q[p]   = 1'b0;
      in_svc_q[p]    = 1'b0;
      out_pend_q[p]  = 1'b0;
      wait_dir_q[p]  = 1'b0;
      wait_imsk_q[p] = 1'b0;
    end
  endtask

  function automatic logic chain_req();
    for (int p = 0; p < 2; p++) begin
      if (in_svc_q[p]) return 1'b0;
      if (irq_req_q[p]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void write_control(int p, logic [7:0] v);
    if (wait_dir_q[p]) begin
      wait_dir_q[p] = 1'b0;
      dir_mask_q[p] = v;
    end else if (wait_imsk_q[p]) begin
      wait_imsk_q[p] = 1'b0;
    end else if (!v[0]) begin
      vec_q[p] = v & pio_pkg::VEC_MASK;
    end else begin
      case (v[3:0])
        pio_pkg::CW_MODE: begin
          mode_q[p]     = pio_pkg::mode_e'(v[7:6]);
          wait_dir_q[p] = (mode_q[p] == pio_pkg::MODE_BITCTL);
          out_pend_q[p] = 1'b0;
        end
        pio_pkg::CW_INT_CTL: begin
          irq_en_q[p]    = v[pio_pkg::CW_BIT_IE];
          wait_imsk_q[p] = v[pio_pkg::CW_BIT_MASK_NXT];
          if (!irq_en_q[p]) irq_req_q[p] = 1'b0;
        end
        pio_pkg::CW_INT_EN: begin
          irq_en_q[p] = v[pio_pkg::CW_BIT_IE];
          if (!irq_en_q[p]) irq_req_q[p] = 1'b0;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic pio_pkg::out_beat_t pio_predict(pio_pkg::in_beat_t b);
    pio_pkg::out_beat_t r;
    int                 ap;
    int                 sp;
    logic               done;
    r    = '0;
    ap   = b.reg_addr[1];
    sp   = b.port_sel;
    done = 1'b0;
    r.rdata = pio_pkg::RD_ZERO;
    case (pio_pkg::req_e'(b.req_type))
      pio_pkg::REQ_READ: begin
        if (b.reg_addr[0]) r.rdata = pio_pkg::RD_ALL_ONES;
        else if (mode_q[ap] == pio_pkg::MODE_OUTPUT) r.rdata = out_latch_q[ap];
        else r.rdata = in_latch_q[ap];
      end
      pio_pkg::REQ_WRITE: begin
        if (b.reg_addr[0]) begin
          write_control(ap, b.wdata);
        end else begin
          out_latch_q[ap] = b.wdata;
          out_pend_q[ap]  = 1'b1;
        end
      end
      pio_pkg::REQ_TAKE: begin
        if (out_pend_q[sp]) begin
          out_pend_q[sp] = 1'b0;
          r.rdata        = out_latch_q[sp];
          r.out_valid    = 1'b1;
        end
      end
      pio_pkg::REQ_STROBE: begin
        if (irq_en_q[sp]) irq_req_q[sp] = 1'b1;
      end
      pio_pkg::REQ_ACK: begin
        r.rdata = vec_q[0];
        for (int p = 0; p < 2; p++) begin
          if (!done) begin
            if (in_svc_q[p]) begin
              done = 1'b1;
            end else if (irq_req_q[p]) begin
              irq_req_q[p] = 1'b0;
              in_svc_q[p]  = 1'b1;
              r.rdata      = vec_q[p];
              done         = 1'b1;
            end
          end
        end
      end
      pio_pkg::REQ_RETI: begin
        for (int p = 0; p < 2; p++) begin
          if (!done && in_svc_q[p]) begin
            in_svc_q[p] = 1'b0;
            done        = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.irq_pending    = chain_req();
    r.irq_in_service = in_svc_q[0] | in_svc_q[1];
    return r;
  endfunction

  task automatic log_mismatch(string what, int got, int exp_v);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_v);
    err_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_ports();
      exp_beats_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (exp_beats_q.size() == 0) begin
          log_mismatch("unexpected result beat", int'(out_beat_i), 0);
        end else begin
          want = exp_beats_q.pop_front();
          if (out_beat_i.rdata !== want.rdata)
            log_mismatch("rdata", out_beat_i.rdata, want.rdata);
          if (out_beat_i.out_valid !== want.out_valid)
            log_mismatch("out_valid", out_beat_i.out_valid, want.out_valid);
          if (out_beat_i.irq_pending !== want.irq_pending)
            log_mismatch("irq_pending", out_beat_i.irq_pending, want.irq_pending);
          if (out_beat_i.irq_in_service !== want.irq_in_service)
            log_mismatch("irq_in_service", out_beat_i.irq_in_service,
                         want.irq_in_service);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp_beats_q.push_back(pio_predict(in_beat_i));
      end
    end
    pend_cnt_o = exp_beats_q.size();
  end

endmodule

/* sim/parallel_io_port_interrupt_controller_core_tb.sv */
`timescale 1ns / 100ps

module parallel_io_port_interrupt_controller_core_tb;

  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam logic       PORT_A       = 1'b0;
  localparam logic       PORT_B       = 1'b1;
  localparam logic       SEL_DATA     = 1'b0;
  localparam logic       SEL_CTRL     = 1'b1;
  localparam int         WDOG_LIMIT   = 4000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  pio_pkg::in_beat_t  in_beat_i;
  logic               out_valid_o;
  logic               out_stall_i;
  pio_pkg::out_beat_t out_beat_o;

  int err_cnt;
  int pend_cnt;
  int n_sent;
  int idle_pct;
  int stall_pct;
  int wdog_cnt;

  parallel_io_port_interrupt_controller_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  parallel_io_port_interrupt_controller_core_chk i_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_i  (out_beat_o),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog_cnt = 0;
      else wdog_cnt++;
      if (wdog_cnt >= WDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic pio_pkg::in_beat_t mk_beat(logic [2:0] t, logic [1:0] a, logic s,
                                                logic [7:0] d);
    pio_pkg::in_beat_t b;
    b.req_type = t;
    b.reg_addr = a;
    b.port_sel = s;
    b.wdata    = d;
    return b;
  endfunction

  function automatic pio_pkg::in_beat_t wr_beat(logic p, logic ctrl, logic [7:0] d);
    return mk_beat(pio_pkg::REQ_WRITE, {p, ctrl}, 1'($urandom), d);
  endfunction

  function automatic pio_pkg::in_beat_t rd_beat(logic p, logic ctrl);
    return mk_beat(pio_pkg::REQ_READ, {p, ctrl}, 1'($urandom), 8'($urandom));
  endfunction

  // take/strobe address a port through port_sel, the rest is noise
  function automatic pio_pkg::in_beat_t port_beat(pio_pkg::req_e t, logic p);
    return mk_beat(t, 2'($urandom), p, 8'($urandom));
  endfunction

  function automatic logic [7:0] ctrl_word();
    case ($urandom_range(4))
      0:       return {7'($urandom), 1'b0};
      1:       return {2'($urandom), 2'($urandom), pio_pkg::CW_MODE};
      2:       return {4'($urandom), pio_pkg::CW_INT_CTL};
      3:       return {4'($urandom), pio_pkg::CW_INT_EN};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pio_pkg::in_beat_t rand_beat();
    int unsigned w;
    logic [1:0]  a;
    logic [7:0]  d;
    w = $urandom_range(99);
    a = 2'($urandom);
    d = 8'($urandom);
    if (w < 18) return mk_beat(pio_pkg::REQ_READ, a, 1'($urandom), d);
    if (w < 50) begin
      if (a[0]) d = ctrl_word();
      return mk_beat(pio_pkg::REQ_WRITE, a, 1'($urandom), d);
    end
    if (w < 62) return mk_beat(pio_pkg::REQ_TAKE, a, 1'($urandom), d);
    if (w < 74) return mk_beat(pio_pkg::REQ_STROBE, a, 1'($urandom), d);
    if (w < 85) return mk_beat(pio_pkg::REQ_ACK, a, 1'($urandom), d);
    if (w < 96) return mk_beat(pio_pkg::REQ_RETI, a, 1'($urandom), d);
    return mk_beat($urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO, a, 1'($urandom), d);
  endfunction

  task automatic send(pio_pkg::in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // vector, enable, strobe(s), acknowledge, return
  task automatic send_irq_seq();
    logic p;
    p = 1'($urandom);
    send(wr_beat(p, SEL_CTRL, {7'($urandom), 1'b0}));
    case ($urandom_range(2))
      0: begin
        send(wr_beat(p, SEL_CTRL, {1'b1, 2'($urandom), 1'b1, pio_pkg::CW_INT_CTL}));
        send(wr_beat(p, SEL_CTRL, 8'($urandom)));
      end
      1:       send(wr_beat(p, SEL_CTRL, {1'b1, 2'($urandom), 1'b0, pio_pkg::CW_INT_CTL}));
      default: send(wr_beat(p, SEL_CTRL, {1'b1, 3'($urandom), pio_pkg::CW_INT_EN}));
    endcase
    send(port_beat(pio_pkg::REQ_STROBE, p));
    if ($urandom_range(1)) send(port_beat(pio_pkg::REQ_STROBE, !p));
    if ($urandom_range(3) == 0) send(rand_beat());
    send(mk_beat(pio_pkg::REQ_ACK, 2'($urandom), 1'($urandom), 8'($urandom)));
    if ($urandom_range(1))
      send(mk_beat(pio_pkg::REQ_ACK, 2'($urandom), 1'($urandom), 8'($urandom)));
    send(mk_beat(pio_pkg::REQ_RETI, 2'($urandom), 1'($urandom), 8'($urandom)));
    if ($urandom_range(1))
      send(mk_beat(pio_pkg::REQ_RETI, 2'($urandom), 1'($urandom), 8'($urandom)));
  endtask

  task automatic send_port_seq();
    logic p;
    p = 1'($urandom);
    if ($urandom_range(2) == 0) begin
      send(wr_beat(p, SEL_CTRL, {pio_pkg::MODE_BITCTL, 2'($urandom), pio_pkg::CW_MODE}));
      send(wr_beat(p, SEL_CTRL, 8'($urandom)));
    end
    send(wr_beat(p, SEL_CTRL,
                 {$urandom_range(3) ? pio_pkg::MODE_OUTPUT : pio_pkg::MODE_BIDIR,
                  2'($urandom), pio_pkg::CW_MODE}));
    repeat ($urandom_range(1, 3)) send(wr_beat(p, SEL_DATA, 8'($urandom)));
    send(rd_beat(p, SEL_DATA));
    send(port_beat(pio_pkg::REQ_TAKE, p));
    if ($urandom_range(1)) send(port_beat(pio_pkg::REQ_TAKE, p));
  endtask

  task automatic run_phase(int in_idle, int out_stall, int n);
    int target;
    target    = n_sent + n;
    idle_pct  = in_idle;
    stall_pct = out_stall;
    while (n_sent < target) begin
      case ($urandom_range(9))
        0, 1:    send_irq_seq();
        2:       send_port_seq();
        default: send(rand_beat());
      endcase
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_beat_i   <= '0;
    idle_pct    = 0;
    stall_pct   = 0;
    n_sent      = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(rd_beat(PORT_A, SEL_CTRL));
    send(rd_beat(PORT_A, SEL_DATA));
    send(wr_beat(PORT_A, SEL_CTRL, 8'hFE));
    send(wr_beat(PORT_B, SEL_CTRL, 8'h00));
    send(wr_beat(PORT_A, SEL_CTRL, {pio_pkg::MODE_OUTPUT, 2'b00, pio_pkg::CW_MODE}));
    send(wr_beat(PORT_A, SEL_DATA, 8'hFF));
    send(rd_beat(PORT_A, SEL_DATA));
    send(wr_beat(PORT_A, SEL_DATA, 8'h00));
    send(port_beat(pio_pkg::REQ_TAKE, PORT_A));
    send(port_beat(pio_pkg::REQ_TAKE, PORT_A));
    send(wr_beat(PORT_B, SEL_DATA, 8'hA5));
    send(wr_beat(PORT_B, SEL_CTRL, {pio_pkg::MODE_BITCTL, 2'b00, pio_pkg::CW_MODE}));
    send(wr_beat(PORT_B, SEL_CTRL, 8'h5A));
    send(port_beat(pio_pkg::REQ_TAKE, PORT_B));
    send(wr_beat(PORT_B, SEL_CTRL, {1'b1, 2'b00, 1'b1, pio_pkg::CW_INT_CTL}));
    send(wr_beat(PORT_B, SEL_CTRL, {pio_pkg::MODE_BIDIR, 2'b00, pio_pkg::CW_MODE}));
    send(wr_beat(PORT_A, SEL_CTRL, 8'h05));
    send(port_beat(pio_pkg::REQ_STROBE, PORT_A));
    send(wr_beat(PORT_A, SEL_CTRL, {4'h8, pio_pkg::CW_INT_EN}));
    send(port_beat(pio_pkg::REQ_STROBE, PORT_B));
    send(port_beat(pio_pkg::REQ_STROBE, PORT_A));
    send(mk_beat(pio_pkg::REQ_ACK, 2'b11, 1'b1, 8'hFF));
    send(mk_beat(pio_pkg::REQ_ACK, 2'b00, 1'b0, 8'h00));
    send(mk_beat(pio_pkg::REQ_RETI, 2'b01, 1'b0, 8'h00));
    send(mk_beat(pio_pkg::REQ_ACK, 2'b10, 1'b1, 8'h00));
    send(mk_beat(pio_pkg::REQ_RETI, 2'b00, 1'b1, 8'h00));
    send(mk_beat(pio_pkg::REQ_RETI, 2'b00, 1'b0, 8'h00));
    send(port_beat(pio_pkg::REQ_STROBE, PORT_B));
    send(wr_beat(PORT_B, SEL_CTRL, {4'h0, pio_pkg::CW_INT_EN}));
    send(mk_beat(REQ_SPARE_LO, 2'b11, 1'b1, 8'hFF));
    send(mk_beat(REQ_SPARE_HI, 2'b00, 1'b0, 8'h00));

    run_phase(0, 0, 475);
    run_phase(77, 0, 475);
    run_phase(0, 77, 475);
    run_phase(32, 32, 475);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pio_pkg.sv
hw/rtl/pio_port.sv
hw/rtl/parallel_io_port_interrupt_controller_core.sv
sim/parallel_io_port_interrupt_controller_core_chk.sv
sim/parallel_io_port_interrupt_controller_core_tb.sv
